>>> src/polygon_convexity_check_assert.svh
// ---------------------------------------------------------------------------
// polygon_convexity_check assertion macros
// concurrent checks on clk, switched off as a group by NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef POLYGON_CONVEXITY_CHECK_ASSERT_SVH
`define POLYGON_CONVEXITY_CHECK_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define PCC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define PCC_ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PCC_ASSERT(name, prop, msg)
`define PCC_ASSERT_NEVER(name, cond, msg)
`endif

`endif

>>> src/pcc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcc_pkg
// shared constants and types of the polygon convexity check
// ---------------------------------------------------------------------------
package pcc_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int MIN_VERTICES    = 3;

	// front sequencer: taking vertices, then the two closing turns
	typedef enum logic [1:0] {
		FR_TAKE,
		FR_WRAP1,
		FR_WRAP2
	} pcc_front_state_t;

	// control part of one queued job
	typedef struct packed {
		logic has_turn;  // job carries a vertex triple to evaluate
		logic end_poly;  // last job of the polygon, produces the result
		logic too_few;   // polygon ended with fewer than three vertices
	} pcc_job_ctl_t;

	localparam int JOB_CTL_W = $bits(pcc_job_ctl_t);

endpackage

>>> src/polygon_convexity_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// polygon_convexity_check
// convexity test of one closed polygon by the signs of its edge cross products
// ---------------------------------------------------------------------------
// usage
//   s_* stream carries vertices, one per transaction, s_tlast on the final one
//   m_* stream carries one result transaction per polygon
//   a vertex is accepted every cycle while the internal job queue has room
//   a polygon of three or more vertices holds s_tready low after its
//   final vertex while the two closing turns are queued
//   each job passes the queue, the difference and product registers
//   and the result register, where the turn sign is taken; a full
//   polygon's result follows its two closing turn jobs
//   a stalled result register holds the back end; the queue then fills
//   and s_tready drops, nothing is lost
//   reset clears the queue, the sequencer and the turn state; the block
//   starts a fresh polygon after each s_tlast
// ---------------------------------------------------------------------------
`include "polygon_convexity_check_assert.svh"

module polygon_convexity_check import pcc_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// vertex stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// point_x, point_y, then zero fill
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
	input  logic                                  s_tlast,   // polygon end marker
	// result stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// convex, too_few_points, then zero fill
	output logic [7:0]                            m_tdata
);

	localparam int JOB_W = 6 * COORD_WIDTH + JOB_CTL_W;

	logic signed [COORD_WIDTH-1:0] point_x, point_y;
	logic                          q_push, q_full, q_pop, q_valid;
	logic [JOB_W-1:0]              q_wdata, q_rdata;
	logic                          convex, too_few_points;

	// unpack vertex transaction
	assign point_x = s_tdata[COORD_WIDTH-1:0];
	assign point_y = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

	// front: vertex history and job issue
	pcc_front #(
		.COORD_WIDTH (COORD_WIDTH),
		.JOB_W       (JOB_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.point_x    (point_x),
		.point_y    (point_y),
		.poly_end   (s_tlast),
		.q_push     (q_push),
		.q_data     (q_wdata),
		.q_full     (q_full)
	);

	// decoupling queue of turn jobs
	pcc_queue #(
		.DATA_W (JOB_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_rdata)
	);

	// back: cross product sign, direction tracking, result
	pcc_back #(
		.COORD_WIDTH (COORD_WIDTH),
		.JOB_W       (JOB_W)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_data         (q_rdata),
		.q_pop          (q_pop),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.convex         (convex),
		.too_few_points (too_few_points)
	);

	assign m_tdata = {6'b0, too_few_points, convex};

	// checks
	`PCC_ASSERT_NEVER(a_no_push_full, q_push && q_full, "job pushed into full queue")
	`PCC_ASSERT_NEVER(a_no_pop_empty, q_pop && !q_valid, "job popped from empty queue")
	`PCC_ASSERT(a_result_excl, m_tvalid |-> !(m_tdata[0] && m_tdata[1]), "convex with too few points")

endmodule

>>> src/pcc_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcc_queue
// small show-ahead fifo between front and back
// ---------------------------------------------------------------------------
module pcc_queue import pcc_pkg::*; #(
	parameter int DATA_W = 64,
	parameter int DEPTH  = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output logic [DATA_W-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DATA_W-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W:0]    count_q;

	assign full     = (count_q == (PTR_W+1)'(DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> src/pcc_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcc_front
// takes vertices, keeps the vertex history and queues turn jobs
// ---------------------------------------------------------------------------
module pcc_front import pcc_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int JOB_W       = 6 * COORD_WIDTH_DEF + JOB_CTL_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic                          poly_end,
	output logic                          q_push,
	output logic [JOB_W-1:0]              q_data,
	input  logic                          q_full
);

	pcc_front_state_t state_q, state_nxt;
	logic [1:0]       count_q;

	logic [COORD_WIDTH-1:0] first_x_q, first_y_q, second_x_q, second_y_q;
	logic [COORD_WIDTH-1:0] older_x_q, older_y_q, newer_x_q, newer_y_q;

	logic [COORD_WIDTH-1:0] ax, ay, bx, by, cx, cy;
	pcc_job_ctl_t           ctl;
	logic                   take;
	logic                   have_two;

	assign have_two = (count_q >= 2'd2);
	assign take     = in_valid && in_ready;
	assign q_data   = {ctl, ax, ay, bx, by, cx, cy};

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		q_push    = 1'b0;
		ctl       = '0;
		ax = older_x_q;  ay = older_y_q;
		bx = newer_x_q;  by = newer_y_q;
		cx = point_x;    cy = point_y;
		unique case (state_q)
			FR_TAKE: begin
				in_ready = !q_full;
				if (in_valid && !q_full) begin
					if (have_two) begin
						q_push       = 1'b1;
						ctl.has_turn = 1'b1;
						if (poly_end) begin
							state_nxt = FR_WRAP1;
						end
					end else if (poly_end) begin
						q_push       = 1'b1;
						ctl.end_poly = 1'b1;
						ctl.too_few  = 1'b1;
					end
				end
			end
			FR_WRAP1: begin
				// older, newer, first
				cx = first_x_q;  cy = first_y_q;
				if (!q_full) begin
					q_push       = 1'b1;
					ctl.has_turn = 1'b1;
					state_nxt    = FR_WRAP2;
				end
			end
			FR_WRAP2: begin
				// newer, first, second
				ax = newer_x_q;   ay = newer_y_q;
				bx = first_x_q;   by = first_y_q;
				cx = second_x_q;  cy = second_y_q;
				if (!q_full) begin
					q_push       = 1'b1;
					ctl.has_turn = 1'b1;
					ctl.end_poly = 1'b1;
					state_nxt    = FR_TAKE;
				end
			end
			default: begin
				state_nxt = FR_TAKE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_TAKE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (take && poly_end && !have_two) begin
			count_q <= '0;
		end else if (take && count_q < 2'(MIN_VERTICES)) begin
			count_q <= count_q + 1'b1;
		end else if (state_q == FR_WRAP2 && !q_full) begin
			count_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			older_x_q <= newer_x_q;
			older_y_q <= newer_y_q;
			newer_x_q <= point_x;
			newer_y_q <= point_y;
			if (count_q == 2'd0) begin
				first_x_q <= point_x;
				first_y_q <= point_y;
			end
			if (count_q == 2'd1) begin
				second_x_q <= point_x;
				second_y_q <= point_y;
			end
		end
	end

endmodule

>>> src/pcc_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcc_back
// cross product pipeline, turn direction tracking and result register
// ---------------------------------------------------------------------------
module pcc_back import pcc_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int JOB_W       = 6 * COORD_WIDTH_DEF + JOB_CTL_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  logic [JOB_W-1:0] q_data,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             convex,
	output logic             too_few_points
);

	localparam int W  = COORD_WIDTH;
	localparam int DW = W + 1;
	localparam int PW = 2 * DW;
	localparam int XW = PW + 1;

	pcc_job_ctl_t    q_ctl;
	logic [W-1:0]    ax, ay, bx, by, cx, cy;
	logic            back_en;

	logic                 v_s1, v_s2;
	pcc_job_ctl_t         ctl_s1, ctl_s2;
	logic signed [DW-1:0] dx1_s1, dy1_s1, dx2_s1, dy2_s1;
	logic signed [PW-1:0] p1_s2, p2_s2;

	logic signed [XW-1:0] cross_z;
	logic                 turn_hit, turn_neg;
	logic                 dir_valid_q, dir_neg_q, concave_q;
	logic                 concave_nxt;
	logic                 out_valid_q, convex_q, too_few_q;

	assign {q_ctl, ax, ay, bx, by, cx, cy} = q_data;

	// whole back end holds while a result waits
	assign back_en = !out_valid_q || out_ready;
	assign q_pop   = q_valid && back_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (back_en) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (back_en) begin
			ctl_s1 <= q_ctl;
			dx1_s1 <= $signed({bx[W-1], bx}) - $signed({ax[W-1], ax});
			dy1_s1 <= $signed({by[W-1], by}) - $signed({ay[W-1], ay});
			dx2_s1 <= $signed({cx[W-1], cx}) - $signed({bx[W-1], bx});
			dy2_s1 <= $signed({cy[W-1], cy}) - $signed({by[W-1], by});
			ctl_s2 <= ctl_s1;
			p1_s2  <= dx1_s1 * dy2_s1;
			p2_s2  <= dy1_s1 * dx2_s1;
		end
	end

	assign cross_z     = $signed({p1_s2[PW-1], p1_s2}) - $signed({p2_s2[PW-1], p2_s2});
	assign turn_neg    = cross_z[XW-1];
	assign turn_hit    = v_s2 && ctl_s2.has_turn && (cross_z != '0);
	assign concave_nxt = concave_q || (turn_hit && dir_valid_q && (turn_neg != dir_neg_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_valid_q <= 1'b0;
			dir_neg_q   <= 1'b0;
			concave_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (back_en) begin
			out_valid_q <= v_s2 && ctl_s2.end_poly;
			if (v_s2 && ctl_s2.end_poly) begin
				dir_valid_q <= 1'b0;
				dir_neg_q   <= 1'b0;
				concave_q   <= 1'b0;
			end else begin
				concave_q <= concave_nxt;
				if (turn_hit && !dir_valid_q) begin
					dir_valid_q <= 1'b1;
					dir_neg_q   <= turn_neg;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (back_en && v_s2 && ctl_s2.end_poly) begin
			convex_q  <= !concave_nxt && !ctl_s2.too_few;
			too_few_q <= ctl_s2.too_few;
		end
	end

	assign out_valid      = out_valid_q;
	assign convex         = convex_q;
	assign too_few_points = too_few_q;

endmodule
